FILE: src/scc_pkg.sv
// Shared types and constants for the scaled 3x3 convolution core.
// Holds line-store geometry, window and result types, register codes and scaling constants.
// No dependencies.
`timescale 1ns / 1ps

package scc_pkg;

    localparam int MAX_WIDTH = 128;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WUSE_W = COL_W + 1;
    localparam int PIX_W = 8;
    localparam int ROW_W = 16;
    localparam int KREG_W = 24;
    localparam int IMG_W_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W = 20;
    localparam int QUEUE_DEPTH = 16;

    localparam int PROD_W = 17;
    localparam int RSUM_W = 19;
    localparam int SUM_W = 21;
    localparam int T_W = 20;
    localparam int RECIP_W = 28;
    localparam int MUL_W = T_W + RECIP_W;
    localparam int SHIFT = 27;
    localparam int HI_W = MUL_W - SHIFT;

    // 128*S/125 + 2304 is taken as 128*(S + 300000)/125 - 304896 so that the
    // reciprocal multiply only sees positive values.
    localparam logic [SUM_W-1:0] T_BIAS = SUM_W'(300000);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(137438954);
    localparam logic [HI_W-1:0] Q_BIAS = HI_W'(304896);

    localparam logic [KREG_W-1:0] KERNEL_TOP_RST = 24'h00FF00;
    localparam logic [KREG_W-1:0] KERNEL_MID_RST = 24'hFF05FF;
    localparam logic [KREG_W-1:0] KERNEL_BOT_RST = 24'h00FF00;
    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST = 8'd100;
    localparam logic [ROW_W-1:0] IMAGE_HEIGHT_RST = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL_TOP,
        REG_KERNEL_MID,
        REG_KERNEL_BOT,
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [2:0][2:0][PIX_W-1:0] win_t;
    typedef logic [2:0][KREG_W-1:0] kernel_t;

    typedef struct packed {
        logic valid;
        logic done;
    } tap_ctl_t;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic done;
    } result_t;

endpackage

FILE: src/scc_line_store.sv
// Raster counters, the two-line pixel memory and the 3x3 window register.
// One memory entry per column holds both earlier rows; read on transfer, written back next cycle.
// Depends on scc_pkg.
`timescale 1ns / 1ps

module scc_line_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  scc_pkg::pix_t              pixel,
    input  logic [scc_pkg::WUSE_W-1:0] width_use,
    input  logic [scc_pkg::ROW_W-1:0]  height_use,
    output logic                       item_produces,
    output scc_pkg::tap_ctl_t          tap_ctl,
    output scc_pkg::win_t              window
);
    import scc_pkg::*;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [WUSE_W-1:0] col_ext;
    logic [WUSE_W-1:0] col_inc;
    logic [ROW_W:0] row_inc;
    logic item_done;

    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;
    logic [COL_W-1:0] addr_reg;
    pix_t pix_reg;
    logic live_reg;
    logic produce_reg;
    logic done_reg;
    win_t window_reg;
    tap_ctl_t tap_ctl_reg;

    assign col_ext = {1'b0, col_reg};
    assign col_inc = col_ext + WUSE_W'(1);
    assign row_inc = {1'b0, row_reg} + (ROW_W + 1)'(1);

    assign item_produces = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2))
        && (col_ext < width_use) && (row_reg < height_use);
    assign item_done = (row_reg == height_use - ROW_W'(1))
        && (col_ext == width_use - WUSE_W'(1));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_inc >= width_use)
        begin
            col_next = '0;
            if (row_inc >= {1'b0, height_use})
            begin
                row_next = '0;
            end
            else
            begin
                row_next = row_inc[ROW_W-1:0];
            end
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            live_reg <= 1'b0;
            tap_ctl_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            live_reg <= accept;
            tap_ctl_reg.valid <= live_reg && produce_reg;
            tap_ctl_reg.done <= done_reg;
        end
    end

    // Consecutive items always use different columns, so the write-back of
    // one item never meets the read of the next at the same entry.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= line_mem[col_reg];
            addr_reg <= col_reg;
            pix_reg <= pixel;
            produce_reg <= item_produces;
            done_reg <= item_done;
        end
        if (live_reg)
        begin
            line_mem[addr_reg] <= {rd_data_reg[PIX_W-1:0], pix_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (live_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                window_reg[i][0] <= window_reg[i][1];
                window_reg[i][1] <= window_reg[i][2];
            end
            window_reg[0][2] <= rd_data_reg[2*PIX_W-1:PIX_W];
            window_reg[1][2] <= rd_data_reg[PIX_W-1:0];
            window_reg[2][2] <= pix_reg;
        end
    end

    assign tap_ctl = tap_ctl_reg;
    assign window = window_reg;

endmodule

FILE: src/scc_mac.sv
// Multiply-accumulate and fixed-point scaling pipeline for one 3x3 window.
// Stages: nine products, row sums, biased total, reciprocal multiply, final offset.
// Depends on scc_pkg.
`timescale 1ns / 1ps

module scc_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  scc_pkg::tap_ctl_t   tap_ctl,
    input  scc_pkg::win_t       window,
    input  scc_pkg::kernel_t    kernel,
    output logic                res_valid,
    output scc_pkg::result_t    result
);
    import scc_pkg::*;

    localparam int STAGES = 5;

    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [RSUM_W-1:0] rsum_reg [3];
    logic [T_W-1:0] t_reg;
    logic [MUL_W-1:0] mul_reg;
    logic [OUT_W-1:0] q_reg;
    logic [SUM_W-1:0] total;
    logic [HI_W-1:0] q_wide;
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STAGES-2:0], tap_ctl.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        done_reg <= {done_reg[STAGES-2:0], tap_ctl.done};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_reg[i][j] <= PROD_W'($signed(kernel[i][j*PIX_W +: PIX_W]))
                    * PROD_W'($signed({1'b0, window[i][j]}));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            rsum_reg[i] <= RSUM_W'(prod_reg[i][0]) + RSUM_W'(prod_reg[i][1])
                + RSUM_W'(prod_reg[i][2]);
        end
    end

    assign total = SUM_W'(rsum_reg[0]) + SUM_W'(rsum_reg[1]) + SUM_W'(rsum_reg[2]) + T_BIAS;
    assign q_wide = mul_reg[MUL_W-1:SHIFT] - Q_BIAS;

    always_ff @(posedge clk)
    begin
        t_reg <= total[T_W-1:0];
        mul_reg <= MUL_W'(t_reg) * MUL_W'(RECIP);
        q_reg <= q_wide[OUT_W-1:0];
    end

    assign res_valid = vld_reg[STAGES-1];
    assign result.value = q_reg;
    assign result.done = done_reg[STAGES-1];

endmodule

FILE: src/scc_out_queue.sv
// Result queue between the arithmetic pipeline and the output channel.
// Small register array with read and write pointers and an occupancy count.
// Depends on scc_pkg.
`timescale 1ns / 1ps

module scc_out_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  scc_pkg::result_t push_data,
    input  logic             pop,
    output logic             not_empty,
    output scc_pkg::result_t head
);
    import scc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_t slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic do_pop;

    assign not_empty = (count_reg != '0);
    assign do_pop = pop && not_empty;
    assign head = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/scaled_3x3_convolution_core.sv
// Top level of the scaled 3x3 convolution core: configuration registers,
// flow control and the line store, arithmetic pipeline and result queue.
// Depends on scc_pkg, scc_line_store, scc_mac and scc_out_queue.
//
// Channel   Direction  Signals                               Transfer when
// input     in         pixel, in_valid, in_ready             in_valid && in_ready
// output    out        filtered_value, frame_done,           out_valid && out_ready
//                      out_valid, out_ready
// config    in         cfg_wr_en, cfg_index, cfg_wdata       cfg_wr_en
//
// One pixel per clock while in_ready is high; out_valid rises once a result is queued.
// The line memory is read in the transfer cycle and written back in the next one.
// Up to sixteen results may be outstanding; in_ready falls only when all sixteen
// are in flight or queued, and rises again with the next output transfer.
// Reset clears counters, pipeline valids and the queue; the memory needs no clearing.
`timescale 1ns / 1ps

module scaled_3x3_convolution_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [7:0]                    pixel,
    input  logic                          in_valid,
    output logic                          in_ready,
    output logic [19:0]                   filtered_value,
    output logic                          frame_done,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          cfg_wr_en,
    input  logic [scc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [scc_pkg::KREG_W-1:0]    cfg_wdata
);
    import scc_pkg::*;

    localparam int PEND_W = $clog2(QUEUE_DEPTH + 1);

    logic [KREG_W-1:0] kernel_top_reg;
    logic [KREG_W-1:0] kernel_mid_reg;
    logic [KREG_W-1:0] kernel_bot_reg;
    logic [IMG_W_W-1:0] image_width_reg;
    logic [ROW_W-1:0] image_height_reg;
    logic [PEND_W-1:0] pending_reg;
    logic [PEND_W-1:0] pending_next;

    logic [WUSE_W-1:0] width_use;
    logic [ROW_W-1:0] height_use;
    logic accept;
    logic out_xfer;
    logic item_produces;
    tap_ctl_t tap_ctl;
    win_t window;
    kernel_t kernel;
    logic res_valid;
    result_t result;
    result_t head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_top_reg <= KERNEL_TOP_RST;
            kernel_mid_reg <= KERNEL_MID_RST;
            kernel_bot_reg <= KERNEL_BOT_RST;
            image_width_reg <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KERNEL_TOP:   kernel_top_reg <= cfg_wdata;
                REG_KERNEL_MID:   kernel_mid_reg <= cfg_wdata;
                REG_KERNEL_BOT:   kernel_bot_reg <= cfg_wdata;
                REG_IMAGE_WIDTH:  image_width_reg <= cfg_wdata[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (image_width_reg < IMG_W_W'(3))
        begin
            width_use = WUSE_W'(3);
        end
        else if (32'(image_width_reg) > MAX_WIDTH)
        begin
            width_use = WUSE_W'(MAX_WIDTH);
        end
        else
        begin
            width_use = WUSE_W'(image_width_reg);
        end
    end

    assign height_use = (image_height_reg < ROW_W'(3)) ? ROW_W'(3) : image_height_reg;
    assign kernel = {kernel_bot_reg, kernel_mid_reg, kernel_top_reg};

    assign in_ready = (pending_reg != PEND_W'(QUEUE_DEPTH));
    assign accept = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;
    assign pending_next = pending_reg + PEND_W'(accept && item_produces) - PEND_W'(out_xfer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    scc_line_store u_line_store (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .pixel         (pixel),
        .width_use     (width_use),
        .height_use    (height_use),
        .item_produces (item_produces),
        .tap_ctl       (tap_ctl),
        .window        (window)
    );

    scc_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .tap_ctl   (tap_ctl),
        .window    (window),
        .kernel    (kernel),
        .res_valid (res_valid),
        .result    (result)
    );

    scc_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (result),
        .pop       (out_ready),
        .not_empty (out_valid),
        .head      (head)
    );

    assign filtered_value = head.value;
    assign frame_done = head.done;

endmodule

FILE: src/scc_checker.sv
// Port-level checks for the scaled 3x3 convolution core, bound to the top level.
// Covers reset, output hold, input flow control and the result range.
// Depends on scaled_3x3_convolution_core.
`timescale 1ns / 1ps

module scc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic [19:0] filtered_value,
    input logic        frame_done,
    input logic        out_valid,
    input logic        out_ready
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("Output valid after reset.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(filtered_value)
            && $stable(frame_done))
        else $error("Stalled result changed.");

    a_ready_holds_low: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && !(out_valid && out_ready) |=> !in_ready)
        else $error("Input ready rose without an output transfer.");

    a_ready_recovers: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && out_valid && out_ready |=> in_ready)
        else $error("Input ready stayed low after an output transfer.");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(filtered_value) >= -20'sd298507)
            && ($signed(filtered_value) <= 20'sd303114))
        else $error("Result out of range.");

endmodule

bind scaled_3x3_convolution_core scc_checker u_scc_checker (.*);

FILE: verif/testbench.sv
// Self-checking testbench for scaled_3x3_convolution_core: random raster pixel streams,
// register settings changed between transfers, results checked against a local predictor.
// Depends on scc_pkg and the scaled_3x3_convolution_core RTL.
`timescale 1ns / 1ps

module testbench;

    import scc_pkg::*;

    localparam int PIPE_LATENCY = 8;
    localparam int DRAIN_CYCLES = PIPE_LATENCY + 4;
    localparam int RANDOM_PIXELS = 700;
    localparam int FRAME_SEND_CAP = 200;
    localparam int READY_ALWAYS = 0;
    localparam int READY_MOSTLY = 1;
    localparam int READY_RARELY = 2;
    localparam int READY_PULSED = 3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic [7:0] pixel = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [19:0] filtered_value;
    logic frame_done;
    logic out_valid;
    logic out_ready = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [KREG_W-1:0] cfg_wdata = '0;

    pix_t pending_pixels[$];
    result_t expected_filtered[$];
    int fail_count = 0;
    logic in_xfer = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    int ready_mode = READY_ALWAYS;
    int ready_mode_left = 0;

    logic [KREG_W-1:0] kernel_reg [3];
    logic [IMG_W_W-1:0] img_width;
    logic [ROW_W-1:0] img_height;
    pix_t row_above [MAX_WIDTH];
    pix_t row_two_above [MAX_WIDTH];
    pix_t pred_win [3][3];
    int pred_col;
    int pred_row;

    scaled_3x3_convolution_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .pixel          (pixel),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .filtered_value (filtered_value),
        .frame_done     (frame_done),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int width_in_use();
        if (img_width < 3)
        begin
            return 3;
        end
        if (img_width > MAX_WIDTH)
        begin
            return MAX_WIDTH;
        end
        return int'(img_width);
    endfunction

    function automatic int height_in_use();
        return (img_height < 3) ? 3 : int'(img_height);
    endfunction

    function automatic void convolve_pixel(input pix_t px);
        int w;
        int h;
        int c;
        int r;
        int ci;
        int s;
        int num;
        int q;
        result_t res;
        w = width_in_use();
        h = height_in_use();
        c = pred_col;
        r = pred_row;
        ci = c % MAX_WIDTH;
        for (int i = 0; i < 3; i++)
        begin
            pred_win[i][0] = pred_win[i][1];
            pred_win[i][1] = pred_win[i][2];
        end
        pred_win[0][2] = row_two_above[ci];
        pred_win[1][2] = row_above[ci];
        pred_win[2][2] = px;
        row_two_above[ci] = row_above[ci];
        row_above[ci] = px;
        if (r >= 2 && c >= 2 && c < w && r < h)
        begin
            s = 0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    s += int'($signed(kernel_reg[i][8*j +: 8])) * int'(pred_win[i][j]);
                end
            end
            num = s * 128;
            q = num / 125;
            if (num % 125 != 0 && num < 0)
            begin
                q -= 1;
            end
            q += 2304;
            res.value = q[OUT_W-1:0];
            res.done = (r == h - 1 && c == w - 1);
            expected_filtered.push_back(res);
        end
        if (c + 1 >= w)
        begin
            pred_col = 0;
            pred_row = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            pred_col = c + 1;
        end
    endfunction

    function automatic int frame_remainder();
        int c = pred_col;
        int r = pred_row;
        int w = width_in_use();
        int h = height_in_use();
        int n = 0;
        do
        begin
            n++;
            if (c + 1 >= w)
            begin
                c = 0;
                r = (r + 1 >= h) ? 0 : r + 1;
            end
            else
            begin
                c++;
            end
        end
        while ((c != 0 || r != 0) && n < FRAME_SEND_CAP);
        return n;
    endfunction

    function automatic logic [KREG_W-1:0] random_kernel();
        logic [KREG_W-1:0] k;
        for (int j = 0; j < 3; j++)
        begin
            case ($urandom_range(0, 7))
                0: k[8*j +: 8] = 8'h80;
                1: k[8*j +: 8] = 8'h7F;
                2: k[8*j +: 8] = 8'hFF;
                default: k[8*j +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        return k;
    endfunction

    function automatic pix_t random_pixel();
        if ($urandom_range(0, 7) == 0)
        begin
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [KREG_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (index)
            REG_KERNEL_TOP: kernel_reg[0] = data;
            REG_KERNEL_MID: kernel_reg[1] = data;
            REG_KERNEL_BOT: kernel_reg[2] = data;
            REG_IMAGE_WIDTH: img_width = data[IMG_W_W-1:0];
            REG_IMAGE_HEIGHT: img_height = data[ROW_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_random_pixels(input int count);
        for (int n = 0; n < count; n++)
        begin
            pending_pixels.push_back(random_pixel());
        end
    endtask

    task automatic wait_until_idle();
        while (pending_pixels.size() != 0 || in_valid || expected_filtered.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_xfer)
        begin
            in_valid <= 1'b1;
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            in_valid <= 1'b0;
        end
        else if (pending_pixels.size() != 0)
        begin
            pixel <= pending_pixels.pop_front();
            in_valid <= 1'b1;
            if (burst_left > 1)
            begin
                burst_left--;
            end
            else
            begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (ready_mode_left == 0)
        begin
            ready_mode = $urandom_range(READY_ALWAYS, READY_PULSED);
            ready_mode_left = $urandom_range(16, 96);
        end
        else
        begin
            ready_mode_left--;
        end
        case (ready_mode)
            READY_ALWAYS: out_ready <= 1'b1;
            READY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
            READY_RARELY: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (ready_mode_left % 8 == 0);
        endcase
    end

    always @(posedge clk)
    begin : result_check
        result_t oldest;
        in_xfer = in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_filtered.size() == 0)
            begin
                $error("filtered_value: unexpected transfer, actual %0d",
                       $signed(filtered_value));
                fail_count++;
            end
            else
            begin
                oldest = expected_filtered.pop_front();
                if (filtered_value !== oldest.value)
                begin
                    $error("filtered_value: expected %0d, actual %0d",
                           $signed(oldest.value), $signed(filtered_value));
                    fail_count++;
                end
                if (frame_done !== oldest.done)
                begin
                    $error("frame_done: expected %0d, actual %0d", oldest.done, frame_done);
                    fail_count++;
                end
            end
        end
        if (rst_n && in_xfer)
        begin
            convolve_pixel(pixel);
        end
    end

    initial
    begin : stimulus
        int sent;
        int count;
        kernel_reg[0] = KERNEL_TOP_RST;
        kernel_reg[1] = KERNEL_MID_RST;
        kernel_reg[2] = KERNEL_BOT_RST;
        img_width = IMAGE_WIDTH_RST;
        img_height = IMAGE_HEIGHT_RST;
        pred_col = 0;
        pred_row = 0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            row_above[i] = '0;
            row_two_above[i] = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pred_win[i][j] = '0;
            end
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset kernel on a 4x3 frame; a height below three is clamped.
        write_register(REG_IMAGE_WIDTH, 24'd4);
        write_register(REG_IMAGE_HEIGHT, 24'd0);
        pending_pixels = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0,
                           8'd128, 8'd127, 8'd1, 8'd254};
        wait_until_idle();

        // Indexes past the register list must be ignored.
        for (int idx = REG_IMAGE_HEIGHT + 1; idx < (1 << CFG_IDX_W); idx++)
        begin
            write_register(CFG_IDX_W'(idx), {KREG_W{1'b1}});
        end

        // Largest and smallest sums on a 3x3 frame with clamped width and height.
        write_register(REG_KERNEL_TOP, 24'h7F7F7F);
        write_register(REG_KERNEL_MID, 24'h7F7F7F);
        write_register(REG_KERNEL_BOT, 24'h7F7F7F);
        write_register(REG_IMAGE_WIDTH, 24'd1);
        write_register(REG_IMAGE_HEIGHT, 24'd2);
        repeat (9) pending_pixels.push_back(8'hFF);
        wait_until_idle();
        write_register(REG_KERNEL_TOP, 24'h808080);
        write_register(REG_KERNEL_MID, 24'h808080);
        write_register(REG_KERNEL_BOT, 24'h808080);
        write_register(REG_IMAGE_WIDTH, 24'd2);
        repeat (9) pending_pixels.push_back(8'hFF);
        wait_until_idle();

        // Full-width rows on a tall frame, then the height is cut so the frame ends.
        write_register(REG_KERNEL_TOP, random_kernel());
        write_register(REG_KERNEL_MID, random_kernel());
        write_register(REG_KERNEL_BOT, random_kernel());
        write_register(REG_IMAGE_WIDTH, 24'd128);
        write_register(REG_IMAGE_HEIGHT, 24'd65535);
        send_random_pixels(300);
        wait_until_idle();
        write_register(REG_IMAGE_HEIGHT, 24'd3);
        send_random_pixels(84);
        wait_until_idle();
        sent = 384;

        while (sent < RANDOM_PIXELS)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                write_register(REG_KERNEL_TOP, random_kernel());
            end
            if ($urandom_range(0, 2) == 0)
            begin
                write_register(REG_KERNEL_MID, random_kernel());
            end
            if ($urandom_range(0, 2) == 0)
            begin
                write_register(REG_KERNEL_BOT, random_kernel());
            end
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 19))
                    0: write_register(REG_IMAGE_WIDTH, KREG_W'($urandom_range(0, 2)));
                    1: write_register(REG_IMAGE_WIDTH, KREG_W'($urandom_range(129, 255)));
                    2: write_register(REG_IMAGE_WIDTH, KREG_W'($urandom_range(11, 128)));
                    default: write_register(REG_IMAGE_WIDTH, KREG_W'($urandom_range(3, 10)));
                endcase
            end
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 19))
                    0: write_register(REG_IMAGE_HEIGHT, KREG_W'($urandom_range(0, 2)));
                    1: write_register(REG_IMAGE_HEIGHT, KREG_W'($urandom_range(40000, 65535)));
                    2: write_register(REG_IMAGE_HEIGHT, KREG_W'($urandom_range(7, 30)));
                    default: write_register(REG_IMAGE_HEIGHT, KREG_W'($urandom_range(3, 6)));
                endcase
            end
            count = ($urandom_range(0, 3) != 0) ? frame_remainder() : $urandom_range(1, 40);
            send_random_pixels(count);
            sent += count;
            wait_until_idle();
        end

        if (fail_count == 0 && expected_filtered.size() == 0)
        begin
            $display("scaled_3x3_convolution_core: match");
        end
        else
        begin
            $display("scaled_3x3_convolution_core: mismatch");
        end
        $finish;
    end

    initial
    begin : run_limit
        #5_000_000;
        $display("scaled_3x3_convolution_core: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
src/scc_pkg.sv
src/scc_line_store.sv
src/scc_mac.sv
src/scc_out_queue.sv
src/scaled_3x3_convolution_core.sv
src/scc_checker.sv
verif/testbench.sv
